FILE: rtl/inte_pkg.sv
// ============================================================================
// inte_pkg
// Shared types, constants and the microcode program of the inverter netlist
// tick engine.
// ============================================================================
package inte_pkg;

    localparam int MAX_WIRES = 4096;
    localparam int MAX_GATES = 4096;
    localparam int WIRE_AW   = $clog2(MAX_WIRES);
    localparam int GATE_AW   = $clog2(MAX_GATES);
    localparam int CNT_W     = 13;
    localparam int UPC_W     = 4;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_TOGGLE = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    typedef enum logic {
        CFG_WIRE_COUNT = 1'b0,
        CFG_GATE_COUNT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_GATE_WR,
        ACT_HELD_FLIP,
        ACT_WIRE_SWEEP,
        ACT_GATE_SWEEP
    } action_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_START,
        COND_LOOP
    } cond_t;

    typedef struct packed {
        action_t           act;
        cond_t             cond;
        logic [UPC_W-1:0]  next;
        logic              strobe;
        logic              rd_out;
    } uop_t;

    localparam logic [UPC_W-1:0] STEP_CLEAR  = 4'd0;
    localparam logic [UPC_W-1:0] STEP_IDLE   = 4'd1;
    localparam logic [UPC_W-1:0] STEP_LOAD   = 4'd2;
    localparam logic [UPC_W-1:0] STEP_TOG_RD = 4'd3;
    localparam logic [UPC_W-1:0] STEP_TOG_WR = 4'd4;
    localparam logic [UPC_W-1:0] STEP_RD_RD  = 4'd5;
    localparam logic [UPC_W-1:0] STEP_RD_OUT = 4'd6;
    localparam logic [UPC_W-1:0] STEP_TICK_W = 4'd7;
    localparam logic [UPC_W-1:0] STEP_TICK_G = 4'd8;
    localparam logic [UPC_W-1:0] STEP_TICK_D = 4'd9;
    localparam logic [UPC_W-1:0] STEP_TICK_E = 4'd10;

    function automatic uop_t uop_rom(input logic [UPC_W-1:0] upc);
        uop_t u;
        case (upc)
            STEP_CLEAR:  u = '{ACT_CLEAR,      COND_LOOP,   STEP_IDLE,   1'b0, 1'b0};
            STEP_IDLE:   u = '{ACT_NONE,       COND_START,  STEP_IDLE,   1'b0, 1'b0};
            STEP_LOAD:   u = '{ACT_GATE_WR,    COND_ALWAYS, STEP_IDLE,   1'b1, 1'b0};
            STEP_TOG_RD: u = '{ACT_NONE,       COND_ALWAYS, STEP_TOG_WR, 1'b0, 1'b0};
            STEP_TOG_WR: u = '{ACT_HELD_FLIP,  COND_ALWAYS, STEP_IDLE,   1'b1, 1'b0};
            STEP_RD_RD:  u = '{ACT_NONE,       COND_ALWAYS, STEP_RD_OUT, 1'b0, 1'b0};
            STEP_RD_OUT: u = '{ACT_NONE,       COND_ALWAYS, STEP_IDLE,   1'b1, 1'b1};
            STEP_TICK_W: u = '{ACT_WIRE_SWEEP, COND_LOOP,   STEP_TICK_G, 1'b0, 1'b0};
            STEP_TICK_G: u = '{ACT_GATE_SWEEP, COND_LOOP,   STEP_TICK_D, 1'b0, 1'b0};
            STEP_TICK_D: u = '{ACT_NONE,       COND_ALWAYS, STEP_TICK_E, 1'b0, 1'b0};
            STEP_TICK_E: u = '{ACT_NONE,       COND_ALWAYS, STEP_IDLE,   1'b1, 1'b0};
            default:     u = '{ACT_NONE,       COND_ALWAYS, STEP_IDLE,   1'b0, 1'b0};
        endcase
        return u;
    endfunction

    function automatic logic [UPC_W-1:0] dispatch(input func_t f);
        logic [UPC_W-1:0] s;
        case (f)
            FUNC_LOAD:   s = STEP_LOAD;
            FUNC_TOGGLE: s = STEP_TOG_RD;
            FUNC_TICK:   s = STEP_TICK_W;
            FUNC_READ:   s = STEP_RD_RD;
            default:     s = STEP_IDLE;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/inverter_netlist_tick_engine_unit.sv
// ============================================================================
// inverter_netlist_tick_engine_unit
// Microcoded engine that loads a table of inverter gates, toggles held wire
// power, advances the netlist one tick at a time and reads back wire state.
// ============================================================================
//
//   Channel   Handshake              Word
//   -------   --------------------   ----------------------------------------
//   command   start / busy           func, gate_slot, source_wire,
//                                    target_wire, wire_sel, press_valid,
//                                    press_wire
//   result    done (one cycle)       level, held
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A tick makes one step per wire and one step per gate on the single read
// and write port of each wire memory. After reset a clearing pass zeroes
// the wire memories while busy is high; configuration writes are taken at
// all times.
// The result receiver cannot stall, so done is never held off.
module inverter_netlist_tick_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [11:0] gate_slot,
    input  logic [11:0] source_wire,
    input  logic [11:0] target_wire,
    input  logic [11:0] wire_sel,
    input  logic        press_valid,
    input  logic [11:0] press_wire,
    output logic        done,
    output logic        level,
    output logic        held,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int AW  = inte_pkg::WIRE_AW;
    localparam int GW  = inte_pkg::GATE_AW;
    localparam int CW  = inte_pkg::CNT_W;
    localparam int UW  = inte_pkg::UPC_W;

    logic [UW-1:0]   upc_reg, upc_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   wire_count_reg, gate_count_reg;
    logic            done_reg, done_next;
    logic            level_reg, level_next;
    logic            held_reg, held_next;

    logic [1:0]      func_reg;
    logic [GW-1:0]   slot_reg;
    logic [AW-1:0]   src_reg, tgt_reg, sel_reg, press_wire_reg;
    logic            press_vld_reg;

    logic            wsw_vld_reg;
    logic [AW-1:0]   wsw_addr_reg;
    logic            g1_vld_reg, g2_vld_reg;
    logic [AW-1:0]   g2_tgt_reg;

    logic            pend_mem [inte_pkg::MAX_WIRES];
    logic            lvl_mem  [inte_pkg::MAX_WIRES];
    logic            held_mem [inte_pkg::MAX_WIRES];
    logic [2*AW-1:0] gate_mem [inte_pkg::MAX_GATES];

    logic            pend_rd, lvl_rd, held_rd;
    logic [2*AW-1:0] gate_rd;

    inte_pkg::uop_t  uop;
    logic            accept;
    logic [CW-1:0]   limit;
    logic            active;

    logic [AW-1:0]   held_raddr, lvl_raddr;
    logic            pend_we, pend_wd, lvl_we, lvl_wd, held_we, held_wd, gate_we;
    logic [AW-1:0]   pend_wa, lvl_wa, held_wa;
    logic            press_hit;

    assign uop       = inte_pkg::uop_rom(upc_reg);
    assign busy      = (upc_reg != inte_pkg::STEP_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign level     = level_reg;
    assign held      = held_reg;

    always_comb
    begin
        case (uop.act)
            inte_pkg::ACT_CLEAR:      limit = CW'(inte_pkg::MAX_WIRES);
            inte_pkg::ACT_WIRE_SWEEP: limit = wire_count_reg;
            inte_pkg::ACT_GATE_SWEEP: limit = gate_count_reg;
            default:                  limit = '0;
        endcase
    end

    assign active = (cnt_reg < limit);

    always_comb
    begin
        upc_next   = upc_reg;
        cnt_next   = cnt_reg;
        done_next  = uop.strobe;
        level_next = uop.rd_out ? lvl_rd : 1'b0;
        held_next  = uop.rd_out ? held_rd : 1'b0;
        case (uop.cond)
            inte_pkg::COND_START:
            begin
                if (start)
                begin
                    upc_next = inte_pkg::dispatch(inte_pkg::func_t'(func));
                end
            end
            inte_pkg::COND_LOOP:
            begin
                if (active)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                else
                begin
                    cnt_next = '0;
                    upc_next = uop.next;
                end
            end
            default:
            begin
                upc_next = uop.next;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg        <= inte_pkg::STEP_CLEAR;
            cnt_reg        <= '0;
            done_reg       <= 1'b0;
            level_reg      <= 1'b0;
            held_reg       <= 1'b0;
            wire_count_reg <= CW'(inte_pkg::MAX_WIRES);
            gate_count_reg <= '0;
            wsw_vld_reg    <= 1'b0;
            g1_vld_reg     <= 1'b0;
            g2_vld_reg     <= 1'b0;
        end
        else
        begin
            upc_reg     <= upc_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
            level_reg   <= level_next;
            held_reg    <= held_next;
            wsw_vld_reg <= (uop.act == inte_pkg::ACT_WIRE_SWEEP) && active;
            g1_vld_reg  <= (uop.act == inte_pkg::ACT_GATE_SWEEP) && active;
            g2_vld_reg  <= g1_vld_reg;
            if (cfg_valid && cfg_ready)
            begin
                case (inte_pkg::cfg_idx_t'(cfg_index))
                    inte_pkg::CFG_WIRE_COUNT:
                        wire_count_reg <= (cfg_data > CW'(inte_pkg::MAX_WIRES))
                                          ? CW'(inte_pkg::MAX_WIRES) : cfg_data;
                    inte_pkg::CFG_GATE_COUNT:
                        gate_count_reg <= (cfg_data > CW'(inte_pkg::MAX_GATES))
                                          ? CW'(inte_pkg::MAX_GATES) : cfg_data;
                    default:
                        gate_count_reg <= gate_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg       <= func;
            slot_reg       <= gate_slot;
            src_reg        <= source_wire;
            tgt_reg        <= target_wire;
            sel_reg        <= wire_sel;
            press_vld_reg  <= press_valid;
            press_wire_reg <= press_wire;
        end
        wsw_addr_reg <= cnt_reg[AW-1:0];
        g2_tgt_reg   <= gate_rd[AW-1:0];
    end

    assign press_hit = press_vld_reg && (press_wire_reg == wsw_addr_reg);

    assign held_raddr = (uop.act == inte_pkg::ACT_WIRE_SWEEP) ? cnt_reg[AW-1:0] : sel_reg;
    assign lvl_raddr  = g1_vld_reg ? gate_rd[2*AW-1:AW] : sel_reg;

    always_comb
    begin
        pend_we = 1'b0;
        pend_wa = cnt_reg[AW-1:0];
        pend_wd = 1'b0;
        lvl_we  = 1'b0;
        lvl_wa  = cnt_reg[AW-1:0];
        lvl_wd  = 1'b0;
        held_we = 1'b0;
        held_wa = cnt_reg[AW-1:0];
        held_wd = 1'b0;
        gate_we = (uop.act == inte_pkg::ACT_GATE_WR);
        if ((uop.act == inte_pkg::ACT_CLEAR) && active)
        begin
            pend_we = 1'b1;
            lvl_we  = 1'b1;
            held_we = 1'b1;
        end
        else if (wsw_vld_reg)
        begin
            pend_we = 1'b1;
            pend_wa = wsw_addr_reg;
            lvl_we  = 1'b1;
            lvl_wa  = wsw_addr_reg;
            lvl_wd  = pend_rd | held_rd | press_hit;
        end
        else if (g2_vld_reg && !lvl_rd && ({1'b0, g2_tgt_reg} < wire_count_reg))
        begin
            pend_we = 1'b1;
            pend_wa = g2_tgt_reg;
            pend_wd = 1'b1;
        end
        if (uop.act == inte_pkg::ACT_HELD_FLIP)
        begin
            held_we = 1'b1;
            held_wa = sel_reg;
            held_wd = ~held_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[pend_wa] <= pend_wd;
        end
        pend_rd <= pend_mem[cnt_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            lvl_mem[lvl_wa] <= lvl_wd;
        end
        lvl_rd <= lvl_mem[lvl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (held_we)
        begin
            held_mem[held_wa] <= held_wd;
        end
        held_rd <= held_mem[held_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (gate_we && (func_reg == inte_pkg::FUNC_LOAD))
        begin
            gate_mem[slot_reg] <= {src_reg, tgt_reg};
        end
        gate_rd <= gate_mem[cnt_reg[GW-1:0]];
    end

endmodule

FILE: rtl/inte_checker.sv
// ============================================================================
// inte_checker
// Port-level checks of the inverter netlist tick engine, bound to the top
// level.
// ============================================================================
module inte_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        level,
    input logic        held,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // A command that is taken keeps the engine busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after an accepted command");

    // A result word appears once the engine has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while a command is still running");

    // Each command yields a single result word.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result word repeated");

    // Level and held are zero outside a result word.
    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!level && !held))
        else $error("result fields set without a result word");

    // Register writes are never held off.
    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write held off");

endmodule

bind inverter_netlist_tick_engine_unit inte_checker u_inte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .level     (level),
    .held      (held),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

FILE: tb/inverter_netlist_tick_engine_unit_tb.sv
// ============================================================================
// inverter_netlist_tick_engine_unit_tb
// Self-checking testbench for the inverter netlist tick engine. Commands are
// sent in random bursts and each one is run through a behavioral copy of the
// engine once busy has dropped. Every done word is checked against the oldest
// prediction. Directed checks cover reset, out-of-range wires and the count
// extremes. Random rounds and a tick over the widest wire count follow.
// ============================================================================
module inverter_netlist_tick_engine_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW  = inte_pkg::MAX_WIRES;
    localparam int NG  = inte_pkg::MAX_GATES;
    localparam int WAW = inte_pkg::WIRE_AW;
    localparam int GAW = inte_pkg::GATE_AW;
    localparam int CW  = inte_pkg::CNT_W;

    typedef struct {
        inte_pkg::func_t    fn;
        logic [GAW-1:0]     slot;
        logic [WAW-1:0]     src;
        logic [WAW-1:0]     dst;
        logic [WAW-1:0]     sel;
        logic               pv;
        logic [WAW-1:0]     pw;
    } engine_cmd_t;

    typedef struct packed {
        logic level;
        logic held;
    } reply_t;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    logic [1:0]         func        = inte_pkg::FUNC_READ;
    logic [11:0]        gate_slot   = '0;
    logic [11:0]        source_wire = '0;
    logic [11:0]        target_wire = '0;
    logic [11:0]        wire_sel    = '0;
    logic               press_valid = 1'b0;
    logic [11:0]        press_wire  = '0;
    logic               done;
    logic               level;
    logic               held;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic               cfg_index   = inte_pkg::CFG_WIRE_COUNT;
    logic [CW-1:0]      cfg_data    = '0;

    logic               nxt_bit      [NW];
    logic               lvl_bit      [NW];
    logic               hold_bit     [NW];
    logic [WAW-1:0]     gate_src_tab [NG];
    logic [WAW-1:0]     gate_dst_tab [NG];
    bit                 gate_written [NG];
    int                 wires_used = NW;
    int                 gates_used = 0;

    reply_t             reply_q[$];
    int                 mismatches = 0;
    int                 words_checked = 0;
    int                 n_sent[4] = '{0, 0, 0, 0};
    int                 n_cfg = 0;
    int                 burst_left = 0;

    inverter_netlist_tick_engine_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .gate_slot   (gate_slot),
        .source_wire (source_wire),
        .target_wire (target_wire),
        .wire_sel    (wire_sel),
        .press_valid (press_valid),
        .press_wire  (press_wire),
        .done        (done),
        .level       (level),
        .held        (held),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("inverter_netlist_tick_engine_unit verification failed");
        $finish;
    end

    function automatic reply_t engine_step(input engine_cmd_t c);
        reply_t r;
        r = '0;
        case (c.fn)
            inte_pkg::FUNC_LOAD:
            begin
                gate_src_tab[c.slot] = c.src;
                gate_dst_tab[c.slot] = c.dst;
                gate_written[c.slot] = 1'b1;
            end
            inte_pkg::FUNC_TOGGLE:
                hold_bit[c.sel] = ~hold_bit[c.sel];
            inte_pkg::FUNC_TICK:
            begin
                for (int i = 0; i < wires_used; i++)
                    if (hold_bit[i])
                        nxt_bit[i] = 1'b1;
                if (c.pv && c.pw < wires_used)
                    nxt_bit[c.pw] = 1'b1;
                for (int i = 0; i < wires_used; i++)
                begin
                    lvl_bit[i] = nxt_bit[i];
                    nxt_bit[i] = 1'b0;
                end
                for (int i = 0; i < gates_used; i++)
                    if (gate_dst_tab[i] < wires_used && !lvl_bit[gate_src_tab[i]])
                        nxt_bit[gate_dst_tab[i]] = 1'b1;
            end
            default:
            begin
                r.level = lvl_bit[c.sel];
                r.held  = hold_bit[c.sel];
            end
        endcase
        return r;
    endfunction

    function automatic int loaded_prefix();
        int n;
        n = 0;
        while (n < NG && gate_written[n])
            n++;
        return n;
    endfunction

    function automatic logic [WAW-1:0] pick_wire();
        if (wires_used == 0 || $urandom_range(0, 6) == 0)
            return WAW'($urandom_range(0, NW - 1));
        return WAW'($urandom_range(0, wires_used - 1));
    endfunction

    function automatic engine_cmd_t rand_cmd(input inte_pkg::func_t fn);
        engine_cmd_t c;
        c.fn   = fn;
        c.slot = GAW'($urandom_range(0, NG - 1));
        c.src  = WAW'($urandom_range(0, NW - 1));
        c.dst  = WAW'($urandom_range(0, NW - 1));
        c.sel  = WAW'($urandom_range(0, NW - 1));
        c.pv   = 1'($urandom_range(0, 1));
        c.pw   = WAW'($urandom_range(0, NW - 1));
        return c;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (reply_q.size() == 0)
            begin
                $display("%0t: done word with no prediction pending, level %0b held %0b",
                         $time, level, held);
                mismatches++;
            end
            else
            begin
                reply_t exp_r;
                exp_r = reply_q.pop_front();
                words_checked++;
                if (level !== exp_r.level)
                begin
                    $display("%0t: level mismatch, expected %0b, actual %0b",
                             $time, exp_r.level, level);
                    mismatches++;
                end
                if (held !== exp_r.held)
                begin
                    $display("%0t: held mismatch, expected %0b, actual %0b",
                             $time, exp_r.held, held);
                    mismatches++;
                end
            end
        end
    end

    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 24);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    task automatic send_cmd(input engine_cmd_t c);
        start       <= 1'b1;
        func        <= c.fn;
        gate_slot   <= c.slot;
        source_wire <= c.src;
        target_wire <= c.dst;
        wire_sel    <= c.sel;
        press_valid <= c.pv;
        press_wire  <= c.pw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        reply_q = {reply_q, engine_step(c)};
        n_sent[c.fn]++;
        pace();
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (reply_q.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input inte_pkg::cfg_idx_t idx, input int v);
        logic [CW-1:0] d;
        d = CW'(v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == inte_pkg::CFG_WIRE_COUNT)
            wires_used = (d > NW) ? NW : int'(d);
        else
            gates_used = (d > NG) ? NG : int'(d);
        n_cfg++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_counts(input int wc, input int gc);
        wait_idle();
        write_reg(inte_pkg::CFG_WIRE_COUNT, wc);
        write_reg(inte_pkg::CFG_GATE_COUNT, gc);
    endtask

    task automatic do_load(input int slot, input int src, input int dst);
        engine_cmd_t c;
        c = rand_cmd(inte_pkg::FUNC_LOAD);
        c.slot = GAW'(slot);
        c.src  = WAW'(src);
        c.dst  = WAW'(dst);
        send_cmd(c);
    endtask

    task automatic do_toggle(input int sel);
        engine_cmd_t c;
        c = rand_cmd(inte_pkg::FUNC_TOGGLE);
        c.sel = WAW'(sel);
        send_cmd(c);
    endtask

    task automatic do_tick(input logic pv, input int pw);
        engine_cmd_t c;
        c = rand_cmd(inte_pkg::FUNC_TICK);
        c.pv = pv;
        c.pw = WAW'(pw);
        send_cmd(c);
    endtask

    task automatic do_read(input int sel);
        engine_cmd_t c;
        c = rand_cmd(inte_pkg::FUNC_READ);
        c.sel = WAW'(sel);
        send_cmd(c);
    endtask

    task automatic test_after_reset();
        wait_idle();
        do_read(0);
        do_read(NW - 1);
        do_tick(1'b1, NW - 1);
        do_read(NW - 1);
        do_read(NW - 2);
    endtask

    task automatic test_directed();
        set_counts(8, 0);
        do_load(0, 0, 1);
        do_load(1, 1, 2);
        do_load(2, 2, 0);
        do_load(3, NW - 1, 3);
        do_load(4, 5, 4000);
        do_load(5, 6, 7);
        do_load(NG - 1, NW - 1, NW - 1);
        set_counts(8, 6);
        do_toggle(0);
        do_tick(1'b1, 0);
        for (int w = 0; w < 4; w++)
            do_read(w);
        do_tick(1'b0, 0);
        do_read(1);
        do_read(7);
        do_tick(1'b1, 4000);
        do_read(4000);
        do_read(NW - 1);
        do_toggle(0);
        do_tick(1'b0, 0);
        do_read(0);
    endtask

    task automatic test_count_extremes();
        set_counts(0, 0);
        do_tick(1'b1, 0);
        do_read(0);
        set_counts(1, 6);
        do_tick(1'b1, 0);
        do_read(0);
        do_read(1);
        set_counts(8191, 6);
        do_tick(1'b0, 0);
        do_read(NW - 1);
    endtask

    task automatic test_random_traffic();
        int pick;
        int wc;
        int gc;
        int r;
        engine_cmd_t c;
        for (int round = 0; round < 3; round++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                wc = $urandom_range(1, 24);
            else if (pick == 6)
                wc = NW;
            else if (pick == 7)
                wc = 8191;
            else
                wc = $urandom_range(1, 8191);
            gc = $urandom_range(0, loaded_prefix());
            set_counts(wc, gc);
            for (int k = 0; k < 20; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                begin
                    c = rand_cmd(inte_pkg::FUNC_LOAD);
                    if ($urandom_range(0, 9) != 0)
                        c.slot = GAW'($urandom_range(0, 40));
                    c.src = pick_wire();
                    c.dst = pick_wire();
                end
                else if (r < 40)
                begin
                    c = rand_cmd(inte_pkg::FUNC_TOGGLE);
                    c.sel = pick_wire();
                end
                else if (r < 70)
                begin
                    c = rand_cmd(inte_pkg::FUNC_TICK);
                    c.pw = pick_wire();
                end
                else
                begin
                    c = rand_cmd(inte_pkg::FUNC_READ);
                    c.sel = pick_wire();
                end
                send_cmd(c);
            end
        end
    endtask

    task automatic test_wide_tick();
        set_counts(8191, loaded_prefix());
        do_tick(1'($urandom_range(0, 1)), pick_wire());
        do_read(pick_wire());
        do_read(pick_wire());
    endtask

    initial
    begin
        for (int i = 0; i < NW; i++)
        begin
            nxt_bit[i]  = 1'b0;
            lvl_bit[i]  = 1'b0;
            hold_bit[i] = 1'b0;
        end
        for (int i = 0; i < NG; i++)
        begin
            gate_src_tab[i] = '0;
            gate_dst_tab[i] = '0;
            gate_written[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_directed();
        test_count_extremes();
        test_random_traffic();
        test_wide_tick();

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Covered %0d loads, %0d toggles, %0d ticks and %0d reads.",
                 n_sent[inte_pkg::FUNC_LOAD], n_sent[inte_pkg::FUNC_TOGGLE],
                 n_sent[inte_pkg::FUNC_TICK], n_sent[inte_pkg::FUNC_READ]);
        $display("Made %0d register writes and checked %0d result words.", n_cfg, words_checked);
        if (mismatches == 0)
            $display("inverter_netlist_tick_engine_unit verification clean");
        else
            $display("inverter_netlist_tick_engine_unit verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/inte_pkg.sv
rtl/inverter_netlist_tick_engine_unit.sv
rtl/inte_checker.sv
tb/inverter_netlist_tick_engine_unit_tb.sv
